FILE: design/trf_pkg.sv
package trf_pkg;

  // default record layout
  localparam int TAG_BYTES_DEF     = 6;
  localparam int LENGTH_DIGITS_DEF = 5;

  // field widths
  localparam int BYTE_W   = 8;
  localparam int TAG_W    = 48;
  localparam int OCC_W    = 16;
  localparam int OFFSET_W = 32;
  localparam int LEN_W    = 17;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 48;

  // length accumulator saturation value
  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WANTED_TAG = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_WANTED_OCC = CFG_IDX_W'(1);

  // character codes
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0d;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2b;
  localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
  localparam logic [BYTE_W-1:0] CH_LOW_A = 8'h61;
  localparam logic [BYTE_W-1:0] CH_LOW_Z = 8'h7a;
  localparam logic [BYTE_W-1:0] CASE_GAP = 8'h20;

  // length field parse phase
  typedef enum logic [1:0] {
    PH_SPACE,
    PH_DIGITS,
    PH_DONE,
    PH_NEG
  } trf_phase_t;

  // one input beat as held in the input register
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              area_end;
  } trf_beat_t;

  // core handshake toward the input register
  typedef struct packed {
    logic take;
  } trf_core_ctl_t;

  function automatic logic [BYTE_W-1:0] fold_upper(input logic [BYTE_W-1:0] c);
    logic [BYTE_W-1:0] r;
    r = c;
    if (c >= CH_LOW_A && c <= CH_LOW_Z) begin
      r = c - CASE_GAP;
    end
    return r;
  endfunction

  function automatic logic is_white(input logic [BYTE_W-1:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic is_digit(input logic [BYTE_W-1:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

FILE: design/trf_in_if.sv
interface trf_in_if;
  logic                          valid;
  logic                          ready;
  logic [trf_pkg::BYTE_W-1:0]    data_byte;
  logic                          area_end;

  modport source (output valid, output data_byte, output area_end, input ready);
  modport sink   (input valid, input data_byte, input area_end, output ready);
endinterface

FILE: design/trf_out_if.sv
interface trf_out_if;
  logic                          valid;
  logic                          ready;
  logic                          found;
  logic [trf_pkg::OFFSET_W-1:0]  body_offset;
  logic [trf_pkg::LEN_W-1:0]     body_length;

  modport source (output valid, output found, output body_offset, output body_length,
                  input ready);
  modport sink   (input valid, input found, input body_offset, input body_length,
                  output ready);
endinterface

FILE: design/trf_cfg_if.sv
interface trf_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [trf_pkg::CFG_IDX_W-1:0]   index;
  logic [trf_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: design/tagged_record_finder.sv
// channel   dir   payload                                 beat when
// in_ch     in    data_byte[7:0], area_end                valid & ready
// out_ch    out   found, body_offset[31:0], body_length   valid & ready
// cfg_ch    in    index[3:0], data[47:0]                  valid & ready (ready always high)
//
// one byte beat per cycle while no held result stalls the core
// the path is an input register, one byte of parse logic, then the result register
// rst_n is synchronous; it clears the scan state and the valid bits of both registers and zeroes the config
// a held result stalls the core; the input register still takes one more beat meanwhile if it is empty
module tagged_record_finder #(
  parameter int TAG_BYTES     = trf_pkg::TAG_BYTES_DEF,
  parameter int LENGTH_DIGITS = trf_pkg::LENGTH_DIGITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  trf_in_if.sink     in_ch,
  trf_out_if.source  out_ch,
  trf_cfg_if.sink    cfg_ch
);

  logic [trf_pkg::TAG_W-1:0] wanted_tag_r;
  logic [trf_pkg::OCC_W-1:0] wanted_occ_r;
  trf_pkg::trf_beat_t        in_beat;
  trf_pkg::trf_beat_t        beat;
  logic                      beat_valid;
  trf_pkg::trf_core_ctl_t    core_ctl;

  // configuration registers
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wanted_tag_r <= '0;
      wanted_occ_r <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        trf_pkg::REG_WANTED_TAG: wanted_tag_r <= cfg_ch.data[trf_pkg::TAG_W-1:0];
        trf_pkg::REG_WANTED_OCC: wanted_occ_r <= cfg_ch.data[trf_pkg::OCC_W-1:0];
        default: begin
          wanted_tag_r <= wanted_tag_r;
        end
      endcase
    end
  end

  // input register
  assign in_beat.data_byte = in_ch.data_byte;
  assign in_beat.area_end  = in_ch.area_end;

  trf_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_beat    (in_beat),
    .core_ctl   (core_ctl),
    .beat_valid (beat_valid),
    .beat       (beat)
  );

  // scan logic and result register
  trf_scan_core #(
    .TAG_BYTES     (TAG_BYTES),
    .LENGTH_DIGITS (LENGTH_DIGITS)
  ) u_scan_core (
    .clk               (clk),
    .rst_n             (rst_n),
    .beat_valid        (beat_valid),
    .beat              (beat),
    .core_ctl          (core_ctl),
    .wanted_tag        (wanted_tag_r),
    .wanted_occurrence (wanted_occ_r),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_found         (out_ch.found),
    .out_body_offset   (out_ch.body_offset),
    .out_body_length   (out_ch.body_length)
  );

endmodule

FILE: design/trf_in_stage.sv
module trf_in_stage (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  trf_pkg::trf_beat_t     in_beat,
  input  trf_pkg::trf_core_ctl_t core_ctl,
  output logic                   beat_valid,
  output trf_pkg::trf_beat_t     beat
);

  logic               valid_r;
  logic               valid_nxt;
  trf_pkg::trf_beat_t beat_r;

  // room when empty or when the core takes the held beat this cycle
  assign in_ready = !valid_r || core_ctl.take;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  // control register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload register
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      beat_r <= in_beat;
    end
  end

  assign beat_valid = valid_r;
  assign beat       = beat_r;

endmodule

FILE: design/trf_scan_core.sv
module trf_scan_core #(
  parameter int TAG_BYTES     = trf_pkg::TAG_BYTES_DEF,
  parameter int LENGTH_DIGITS = trf_pkg::LENGTH_DIGITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          beat_valid,
  input  trf_pkg::trf_beat_t            beat,
  output trf_pkg::trf_core_ctl_t        core_ctl,
  input  logic [trf_pkg::TAG_W-1:0]     wanted_tag,
  input  logic [trf_pkg::OCC_W-1:0]     wanted_occurrence,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_found,
  output logic [trf_pkg::OFFSET_W-1:0]  out_body_offset,
  output logic [trf_pkg::LEN_W-1:0]     out_body_length
);

  localparam int HEADER_BYTES = TAG_BYTES + LENGTH_DIGITS;
  localparam int HDR_POS_W    = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;
  localparam int TAG_EXT_W    = 64;
  localparam int ACC_PROD_W   = trf_pkg::LEN_W + 4;

  // scan state
  logic [HDR_POS_W-1:0]         hdr_pos_r,  hdr_pos_nxt;
  logic                         match_r,    match_nxt;
  logic [trf_pkg::LEN_W-1:0]    acc_r,      acc_nxt;
  trf_pkg::trf_phase_t          phase_r,    phase_nxt;
  logic [trf_pkg::LEN_W-1:0]    body_rem_r, body_rem_nxt;
  logic [trf_pkg::OFFSET_W-1:0] byte_pos_r, byte_pos_nxt;
  logic [trf_pkg::OCC_W-1:0]    skip_r,     skip_nxt;
  logic                         done_r,     done_nxt;

  // result register
  logic                         out_valid_r, out_valid_nxt;
  logic                         found_r;
  logic [trf_pkg::OFFSET_W-1:0] offset_r;
  logic [trf_pkg::LEN_W-1:0]    length_r;

  logic                         take;
  logic                         hit;
  logic                         miss;
  logic [trf_pkg::OCC_W-1:0]    skip_cur;
  logic                         match_p;
  logic [trf_pkg::LEN_W-1:0]    acc_p;
  trf_pkg::trf_phase_t          phase_p;
  logic [trf_pkg::LEN_W-1:0]    len_p;
  logic [TAG_EXT_W-1:0]         tag_ext;
  logic [2:0]                   tag_idx;
  logic [trf_pkg::BYTE_W-1:0]   tag_byte;
  logic [trf_pkg::BYTE_W-1:0]   c;
  logic [3:0]                   digit_val;
  logic [ACC_PROD_W-1:0]        acc_prod;

  // a beat moves on when the result slot is free or drains now
  assign take = beat_valid && (!out_valid_r || out_ready);
  assign core_ctl.take = take;

  assign c         = beat.data_byte;
  assign digit_val = 4'(c - trf_pkg::CH_ZERO);
  assign tag_ext   = TAG_EXT_W'(wanted_tag);
  assign tag_idx   = 3'(TAG_BYTES - 1 - int'(hdr_pos_r));
  assign tag_byte  = tag_ext[tag_idx * trf_pkg::BYTE_W +: trf_pkg::BYTE_W];
  assign acc_prod  = (ACC_PROD_W'(acc_r) << 3) + (ACC_PROD_W'(acc_r) << 1)
                     + ACC_PROD_W'(digit_val);

  // one byte of header parsing, body skipping and match counting
  always_comb begin
    hdr_pos_nxt  = hdr_pos_r;
    match_nxt    = match_r;
    acc_nxt      = acc_r;
    phase_nxt    = phase_r;
    body_rem_nxt = body_rem_r;
    byte_pos_nxt = byte_pos_r;
    skip_nxt     = skip_r;
    done_nxt     = done_r;
    hit          = 1'b0;
    miss         = 1'b0;
    match_p      = match_r;
    acc_p        = acc_r;
    phase_p      = phase_r;
    len_p        = '0;
    skip_cur     = (byte_pos_r == '0) ? wanted_occurrence : skip_r;

    if (take) begin
      skip_nxt = skip_cur;
      if (!done_r) begin
        if (body_rem_r != '0) begin
          body_rem_nxt = body_rem_r - 1'b1;
        end else begin
          // tag compare or length character
          if (int'(hdr_pos_r) < TAG_BYTES) begin
            if (trf_pkg::fold_upper(tag_byte) != trf_pkg::fold_upper(c)) begin
              match_p = 1'b0;
            end
          end else begin
            case (phase_r)
              trf_pkg::PH_SPACE: begin
                if (trf_pkg::is_white(c)) begin
                  phase_p = trf_pkg::PH_SPACE;
                end else if (c == trf_pkg::CH_PLUS) begin
                  phase_p = trf_pkg::PH_DIGITS;
                end else if (c == trf_pkg::CH_MINUS) begin
                  phase_p = trf_pkg::PH_NEG;
                end else if (trf_pkg::is_digit(c)) begin
                  acc_p   = trf_pkg::LEN_W'(digit_val);
                  phase_p = trf_pkg::PH_DIGITS;
                end else begin
                  phase_p = trf_pkg::PH_DONE;
                end
              end
              trf_pkg::PH_DIGITS: begin
                if (trf_pkg::is_digit(c)) begin
                  acc_p = (acc_prod > ACC_PROD_W'(trf_pkg::LEN_MAX)) ?
                          trf_pkg::LEN_MAX : acc_prod[trf_pkg::LEN_W-1:0];
                end else begin
                  phase_p = trf_pkg::PH_DONE;
                end
              end
              default: begin
                phase_p = phase_r;
              end
            endcase
          end

          // end of header: decide on the record
          if (int'(hdr_pos_r) + 1 >= HEADER_BYTES) begin
            len_p = (phase_p == trf_pkg::PH_NEG) ? '0 : acc_p;
            if (match_p) begin
              if (skip_cur == '0) begin
                hit      = 1'b1;
                done_nxt = 1'b1;
              end else begin
                skip_nxt = skip_cur - 1'b1;
              end
            end
            body_rem_nxt = len_p;
            hdr_pos_nxt  = '0;
            match_nxt    = 1'b1;
            acc_nxt      = '0;
            phase_nxt    = trf_pkg::PH_SPACE;
          end else begin
            hdr_pos_nxt = hdr_pos_r + 1'b1;
            match_nxt   = match_p;
            acc_nxt     = acc_p;
            phase_nxt   = phase_p;
          end
        end
      end
      byte_pos_nxt = byte_pos_r + 1'b1;

      // area end: report a miss unless the area already had a hit, and restart
      if (beat.area_end) begin
        miss         = !hit && !done_r;
        hdr_pos_nxt  = '0;
        match_nxt    = 1'b1;
        acc_nxt      = '0;
        phase_nxt    = trf_pkg::PH_SPACE;
        body_rem_nxt = '0;
        byte_pos_nxt = '0;
        skip_nxt     = '0;
        done_nxt     = 1'b0;
      end
    end
  end

  // result slot occupancy
  always_comb begin
    if (take) begin
      out_valid_nxt = hit || miss;
    end else begin
      out_valid_nxt = out_valid_r && !out_ready;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_pos_r   <= '0;
      match_r     <= 1'b1;
      acc_r       <= '0;
      phase_r     <= trf_pkg::PH_SPACE;
      body_rem_r  <= '0;
      byte_pos_r  <= '0;
      skip_r      <= '0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      hdr_pos_r   <= hdr_pos_nxt;
      match_r     <= match_nxt;
      acc_r       <= acc_nxt;
      phase_r     <= phase_nxt;
      body_rem_r  <= body_rem_nxt;
      byte_pos_r  <= byte_pos_nxt;
      skip_r      <= skip_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (take && (hit || miss)) begin
      found_r  <= hit;
      offset_r <= hit ? (byte_pos_r + 1'b1) : '0;
      length_r <= hit ? len_p : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_found       = found_r;
  assign out_body_offset = offset_r;
  assign out_body_length = length_r;

endmodule

FILE: design/trf_checker.sv
module trf_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_found,
  input logic [trf_pkg::OFFSET_W-1:0]  out_body_offset,
  input logic [trf_pkg::LEN_W-1:0]     out_body_length
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_found)
      && $stable(out_body_offset) && $stable(out_body_length))
    else $error("result beat changed while stalled");

  // a miss carries zero offset and length
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_body_offset == '0 && out_body_length == '0)
    else $error("not-found beat with nonzero payload");

  // a free result side never stalls the input
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while result side is ready");

  // reset empties the result slot
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind tagged_record_finder trf_checker u_trf_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_found       (out_ch.found),
  .out_body_offset (out_ch.body_offset),
  .out_body_length (out_ch.body_length)
);

FILE: verif/trf_result_checker.sv
module trf_result_checker (
  input  logic clk,
  input  logic rst_n,
  trf_in_if    in_ch,
  trf_out_if   out_ch,
  trf_cfg_if   cfg_ch,
  output int   mismatches,
  output int   results_due
);
  import trf_pkg::*;

  localparam int TAG_N = TAG_BYTES_DEF;
  localparam int HDR_N = TAG_BYTES_DEF + LENGTH_DIGITS_DEF;

  typedef struct packed {
    logic                found;
    logic [OFFSET_W-1:0] body_offset;
    logic [LEN_W-1:0]    body_length;
  } search_result_t;

  search_result_t due_q [$];

  // shadow of the config registers
  logic [TAG_W-1:0] tag_reg;
  logic [OCC_W-1:0] occ_reg;

  // scan state of the current area
  logic [3:0]          hdr_idx;
  logic                tag_ok;
  logic [LEN_W-1:0]    len_acc;
  trf_phase_t          phase;
  logic [LEN_W-1:0]    body_left;
  logic [OFFSET_W-1:0] byte_idx;
  logic [OCC_W-1:0]    skips_left;
  logic                hit_done;

  function automatic logic [BYTE_W-1:0] to_caps(input logic [BYTE_W-1:0] c);
    return (c >= CH_LOW_A && c <= CH_LOW_Z) ? (c & ~CASE_GAP) : c;
  endfunction

  function automatic int field_diff(input string what, input logic [31:0] want,
                                    input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      return 1;
    end
    return 0;
  endfunction

  task automatic clear_scan();
    hdr_idx    = '0;
    tag_ok     = 1'b1;
    len_acc    = '0;
    phase      = PH_SPACE;
    body_left  = '0;
    byte_idx   = '0;
    skips_left = '0;
    hit_done   = 1'b0;
  endtask

  // one length character, atoi style
  task automatic parse_length(input logic [BYTE_W-1:0] c);
    logic        numeral;
    int unsigned grown;
    numeral = (c >= CH_ZERO) && (c <= CH_NINE);
    case (phase)
      PH_SPACE: begin
        if (c == CH_PLUS) begin
          phase = PH_DIGITS;
        end else if (c == CH_MINUS) begin
          phase = PH_NEG;
        end else if (numeral) begin
          len_acc = LEN_W'(c - CH_ZERO);
          phase   = PH_DIGITS;
        end else if (!(c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))) begin
          phase = PH_DONE;
        end
      end
      PH_DIGITS: begin
        if (numeral) begin
          grown   = 32'(len_acc) * 10 + 32'(c - CH_ZERO);
          len_acc = (grown > 32'(LEN_MAX)) ? LEN_MAX : LEN_W'(grown);
        end else begin
          phase = PH_DONE;
        end
      end
      default: ;
    endcase
  endtask

  // predict the outcome of one input beat
  task automatic scan_byte(input logic [BYTE_W-1:0] c, input logic last);
    search_result_t   r;
    logic             produced;
    logic [BYTE_W-1:0] want;
    logic [LEN_W-1:0] len;
    produced = 1'b0;
    if (byte_idx == '0) skips_left = occ_reg;
    if (!hit_done) begin
      if (body_left != '0) begin
        body_left = body_left - 1'b1;
      end else begin
        if (hdr_idx < TAG_N) begin
          want = tag_reg[8*(TAG_N-1-int'(hdr_idx)) +: 8];
          if (to_caps(want) != to_caps(c)) tag_ok = 1'b0;
        end else begin
          parse_length(c);
        end
        // last header byte closes the record
        if (hdr_idx == HDR_N - 1) begin
          len = (phase == PH_NEG) ? '0 : len_acc;
          if (tag_ok) begin
            if (skips_left == '0) begin
              r.found       = 1'b1;
              r.body_offset = byte_idx + 1'b1;
              r.body_length = len;
              due_q.push_back(r);
              produced = 1'b1;
              hit_done = 1'b1;
            end else begin
              skips_left = skips_left - 1'b1;
            end
          end
          body_left = len;
          hdr_idx   = '0;
          tag_ok    = 1'b1;
          len_acc   = '0;
          phase     = PH_SPACE;
        end else begin
          hdr_idx = hdr_idx + 1'b1;
        end
      end
    end
    byte_idx = byte_idx + 1'b1;
    // area end without a hit reports not found
    if (last) begin
      if (!produced && !hit_done) begin
        r = '0;
        due_q.push_back(r);
      end
      clear_scan();
    end
  endtask

  // compare a result beat against the oldest prediction
  task automatic check_result();
    search_result_t want;
    if (due_q.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual found=%0b offset=%0d length=%0d",
               $time, out_ch.found, out_ch.body_offset, out_ch.body_length);
      mismatches++;
    end else begin
      want = due_q.pop_front();
      mismatches += field_diff("found", 32'(want.found), 32'(out_ch.found));
      mismatches += field_diff("body_offset", want.body_offset, out_ch.body_offset);
      mismatches += field_diff("body_length", 32'(want.body_length), 32'(out_ch.body_length));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      tag_reg = '0;
      occ_reg = '0;
      clear_scan();
      due_q.delete();
      mismatches = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) check_result();
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_WANTED_TAG: tag_reg = cfg_ch.data;
          REG_WANTED_OCC: occ_reg = cfg_ch.data[OCC_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) scan_byte(in_ch.data_byte, in_ch.area_end);
    end
    results_due = due_q.size();
  end

endmodule

FILE: verif/tb_tagged_record_finder.sv
module tb_tagged_record_finder;
  import trf_pkg::*;

  localparam int MIN_BYTES     = 750;
  localparam int MIN_AREAS     = 32;
  localparam int CALM_FROM     = 350;
  localparam int CALM_TO       = 520;
  localparam int HOLD_AT       = 200;
  localparam int HOLD_CYCLES   = 90;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = '1;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  logic calm;
  int   sent_bytes = 0;
  int   areas_sent = 0;
  int   mismatches;
  int   results_due;

  logic [TAG_W-1:0]  tag_now;
  logic [BYTE_W-1:0] area_q [$];

  trf_in_if  in_ch ();
  trf_out_if out_ch ();
  trf_cfg_if cfg_ch ();

  tagged_record_finder uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  trf_result_checker scan_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_ch     (cfg_ch),
    .mismatches (mismatches),
    .results_due(results_due)
  );

  always #2 clk = ~clk;

  // no random idling on either side inside this window
  assign calm = (sent_bytes >= CALM_FROM) && (sent_bytes < CALM_TO);

  initial begin
    #400000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // result sink: random stalls plus one long hold-off
  initial begin
    int   hold_left;
    logic hold_armed;
    hold_left    = 0;
    hold_armed   = 1'b1;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_armed && sent_bytes >= HOLD_AT) begin
        hold_armed = 1'b0;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= calm || ($urandom_range(0, 99) >= 6);
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_beat(input logic [BYTE_W-1:0] b, input logic last);
    while (!calm && $urandom_range(0, 99) < 6) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.area_end  <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent_bytes++;
    @(negedge clk);
  endtask

  task automatic send_area();
    int k;
    for (k = 0; k < area_q.size(); k++) send_beat(area_q[k], k == area_q.size() - 1);
    area_q.delete();
    areas_sent++;
  endtask

  // drain all results, then let any trailing beat clear the pipe
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (results_due != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [BYTE_W-1:0] blank_char();
    int w;
    w = $urandom_range(0, 5);
    return (w == 5) ? CH_SPACE : CH_TAB + BYTE_W'(w);
  endfunction

  function automatic logic [TAG_W-1:0] letter_tag();
    logic [TAG_W-1:0] t;
    logic [BYTE_W-1:0] b;
    int k;
    for (k = 0; k < TAG_BYTES_DEF; k++) begin
      b = 8'h41 + BYTE_W'($urandom_range(0, 25));
      if ($urandom_range(0, 1) == 1) b = b | CASE_GAP;
      t[8*k +: 8] = b;
    end
    return t;
  endfunction

  // tag: a case-shuffled hit, a one-bit near miss, or random bytes
  task automatic add_tag();
    int   k, pick, flip;
    logic [BYTE_W-1:0] b;
    pick = $urandom_range(0, 99);
    flip = $urandom_range(0, TAG_BYTES_DEF - 1);
    for (k = 0; k < TAG_BYTES_DEF; k++) begin
      b = tag_now[8*(TAG_BYTES_DEF-1-k) +: 8];
      if (pick < 55) begin
        if ((b | CASE_GAP) >= CH_LOW_A && (b | CASE_GAP) <= CH_LOW_Z &&
            $urandom_range(0, 1) == 1) begin
          b = b ^ CASE_GAP;
        end
      end else if (pick < 75) begin
        if (k == flip) b = b ^ (8'h01 << $urandom_range(0, 4));
      end else begin
        b = BYTE_W'($urandom);
      end
      area_q.push_back(b);
    end
  endtask

  // length field in one of many spellings, then the body it announces
  task automatic add_length_body(output logic stop);
    logic [BYTE_W-1:0] fld [LENGTH_DIGITS_DEF];
    logic [BYTE_W-1:0] b;
    int kind, lead, from, len, v, k;
    stop = 1'b0;
    kind = $urandom_range(0, 11);
    lead = $urandom_range(0, 2);
    from = -1;
    len  = $urandom_range(0, 9);
    for (k = 0; k < LENGTH_DIGITS_DEF; k++) fld[k] = (k < lead) ? blank_char() : CH_ZERO;
    case (kind)
      0, 1, 2: begin
        from = 0;
        len  = $urandom_range(0, 15);
      end
      3, 4: begin
        fld[lead] = blank_char();
        from      = lead + 1;
      end
      5: begin
        fld[lead] = CH_PLUS;
        from      = lead + 1;
      end
      6: begin
        // digit left aligned, stopped by any non-digit
        fld[0] = CH_ZERO + BYTE_W'(len);
        for (k = 1; k < LENGTH_DIGITS_DEF; k++) begin
          b = BYTE_W'($urandom);
          while (b >= CH_ZERO && b <= CH_NINE) b = BYTE_W'($urandom);
          fld[k] = b;
        end
      end
      7: begin
        // minus sign forces length zero
        fld[lead] = CH_MINUS;
        for (k = lead + 1; k < LENGTH_DIGITS_DEF; k++) begin
          fld[k] = CH_ZERO + BYTE_W'($urandom_range(0, 9));
        end
        len = 0;
      end
      8: begin
        // stray character before any digit
        b = BYTE_W'($urandom);
        while ((b >= CH_ZERO && b <= CH_NINE) || b == CH_SPACE ||
               (b >= CH_TAB && b <= CH_CR) || b == CH_PLUS || b == CH_MINUS) begin
          b = BYTE_W'($urandom);
        end
        fld[lead] = b;
        for (k = lead + 1; k < LENGTH_DIGITS_DEF; k++) fld[k] = BYTE_W'($urandom);
        len = 0;
      end
      9: begin
        // sign followed by a blank
        fld[0] = CH_PLUS;
        fld[1] = CH_SPACE;
        for (k = 2; k < LENGTH_DIGITS_DEF; k++) fld[k] = CH_ZERO + BYTE_W'($urandom_range(0, 9));
        len = 0;
      end
      10: begin
        from = 0;
        len  = ($urandom_range(0, 3) == 0) ? 99999 : $urandom_range(0, 99999);
      end
      default: begin
        // noise: alignment is lost for the rest of the area
        for (k = 0; k < LENGTH_DIGITS_DEF; k++) fld[k] = BYTE_W'($urandom);
        len  = $urandom_range(0, 6);
        stop = 1'b1;
      end
    endcase
    if (from >= 0) begin
      v = len;
      for (k = LENGTH_DIGITS_DEF - 1; k >= from; k--) begin
        fld[k] = CH_ZERO + BYTE_W'(v % 10);
        v = v / 10;
      end
    end
    for (k = 0; k < LENGTH_DIGITS_DEF; k++) area_q.push_back(fld[k]);
    // long bodies are cut short by the area end
    if (len > 8) begin
      len  = $urandom_range(0, 8);
      stop = 1'b1;
    end
    repeat (len) area_q.push_back(BYTE_W'($urandom));
  endtask

  task automatic build_area();
    int   recs, cut;
    logic stop;
    recs = $urandom_range(1, 3);
    stop = 1'b0;
    while (recs > 0 && !stop) begin
      add_tag();
      add_length_body(stop);
      recs--;
    end
    case ($urandom_range(0, 19))
      0, 1: begin
        // area ends inside a record
        cut = $urandom_range(1, 10);
        while (cut > 0 && area_q.size() > 1) begin
          void'(area_q.pop_back());
          cut--;
        end
      end
      2, 3: repeat ($urandom_range(1, 4)) area_q.push_back(BYTE_W'($urandom));
      4: begin
        area_q.delete();
        repeat ($urandom_range(1, 3)) area_q.push_back(BYTE_W'($urandom));
      end
      default: ;
    endcase
  endtask

  task automatic pick_setting(input int phase_no);
    logic [OCC_W-1:0] occ;
    case (phase_no % 6)
      0: begin
        tag_now = letter_tag();
        occ     = '0;
      end
      1: begin
        tag_now = letter_tag();
        occ     = OCC_W'(1);
      end
      2: begin
        tag_now = TAG_W'({$urandom, $urandom});
        occ     = OCC_W'($urandom_range(0, 2));
      end
      3: begin
        tag_now = '0;
        occ     = OCC_W'(2);
      end
      4: begin
        tag_now = '1;
        occ     = '1;
      end
      default: begin
        tag_now = letter_tag();
        occ     = OCC_W'($urandom_range(0, 3));
        write_reg(REG_SPARE, CFG_DATA_W'({$urandom, $urandom}));
      end
    endcase
    write_reg(REG_WANTED_TAG, tag_now);
    write_reg(REG_WANTED_OCC, {$urandom, occ});
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    int phase_no;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    in_ch.area_end  = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = '0;
    cfg_ch.data     = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // directed: tag "kEY_07", first hit wanted
    tag_now = 48'h6B45_595F_3037;
    write_reg(REG_WANTED_TAG, tag_now);
    write_reg(REG_WANTED_OCC, '0);
    cfg_ch.valid <= 1'b0;
    // hit in other case, blanks then minus, area ends on the hit beat
    area_q = '{8'h4B, 8'h65, 8'h59, 8'h5F, 8'h30, 8'h37,
               CH_SPACE, CH_TAB, CH_MINUS, CH_ZERO, 8'h33};
    send_area();
    // area ends inside the header
    area_q = '{8'h6B, 8'h45, 8'h59, 8'h5F, 8'h30};
    send_area();
    // single beat areas at the byte extremes
    area_q = '{8'hFF};
    send_area();
    area_q = '{8'h00};
    send_area();

    // random phases, one register setting each
    phase_no = 0;
    while (sent_bytes < MIN_BYTES || areas_sent < MIN_AREAS) begin
      settle();
      pick_setting(phase_no);
      repeat ($urandom_range(3, 6)) begin
        build_area();
        send_area();
      end
      phase_no++;
    end

    settle();
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
